/* hdl/mosm_pkg.sv */
package mosm_pkg;

  // number of oscillators held in the block
  localparam int NUM_OSC = 8;
  localparam int OSC_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int CNT_W = $clog2(NUM_OSC + 1);

  // waveform codes
  localparam logic [2:0] WAVE_TRIANGLE = 3'd0;
  localparam logic [2:0] WAVE_SAW      = 3'd1;
  localparam logic [2:0] WAVE_PULSE    = 3'd2;
  localparam logic [2:0] WAVE_NOISE    = 3'd3;

  // item kinds
  localparam logic KIND_SETTINGS = 1'b0;
  localparam logic KIND_SAMPLE   = 1'b1;

  // active count that selects the narrower output shift
  localparam logic [3:0] FOUR_CHANNELS = 4'd4;

  // per oscillator settings word
  typedef struct packed {
    logic [15:0] frequency;
    logic [15:0] duty;
    logic [2:0]  waveform;
    logic [7:0]  volume;
    logic [3:0]  crush;
  } osc_settings_t;

  localparam osc_settings_t SETTINGS_RESET = '{
    frequency: 16'd0,
    duty:      16'd0,
    waveform:  WAVE_TRIANGLE,
    volume:    8'd0,
    crush:     4'd5
  };

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } mosm_state_t;

  // low bits forced to one by the bitcrush level, saturating at a full byte
  function automatic logic [7:0] crush_mask(input logic [3:0] crush);
    logic [8:0] bit_one;
    logic [8:0] mask_wide;
    bit_one   = 9'd1 << crush;
    mask_wide = bit_one - 9'd1;
    return mask_wide[7:0];
  endfunction

  // raw wave value in -32..31 as a signed byte
  function automatic logic [7:0] wave_value(input logic [2:0]  waveform,
                                            input logic [15:0] phase,
                                            input logic [15:0] duty,
                                            input logic [5:0]  noise_bits);
    logic [7:0] v;
    case (waveform)
      WAVE_TRIANGLE: begin
        if (phase[15]) begin
          v = 8'd31 - {2'b00, phase[14:9]};
        end else begin
          v = {2'b00, phase[14:9]} - 8'd32;
        end
      end
      WAVE_SAW: begin
        v = {2'b00, phase[15:10]} - 8'd32;
      end
      WAVE_PULSE: begin
        v = (phase > duty) ? 8'hE0 : 8'd31;
      end
      WAVE_NOISE: begin
        v = {2'b00, noise_bits} - 8'd32;
      end
      default: begin
        v = 8'd0;
      end
    endcase
    return v;
  endfunction

endpackage

/* hdl/multi_oscillator_sound_mixer.sv */
// Multi-oscillator sound mixer.
// Input channel (in_valid/in_ready): a settings transaction (kind 0) loads
// the frequency, duty, waveform, volume and bitcrush level of oscillator
// osc_index and gives no result. A sample transaction
// (kind 1) steps the noise register, then walks the active oscillators one
// per cycle through the settings and phase memories (registered read, phase
// written back in the same cycle) and gives one left/right byte pair.
// While a sample transaction runs, no new transaction is accepted; its
// result is loaded into the output register from the sample's last state.
// Output channel (out_valid/out_ready): a result is held in the output
// register until taken. Settings transactions are still accepted while a
// result waits; a sample transaction finishing while the output register
// is still full waits in its last state until the receiver takes the
// earlier result.
// Configuration channel (cfg_valid/cfg_ready): writes active_oscillators,
// always ready. Reset restores eight active oscillators, noise register 1,
// zero phases and settings, bitcrush five; per-entry valid bits make
// unwritten memory entries read as their reset values.
module multi_oscillator_sound_mixer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] active_oscillators,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [2:0] osc_index,
  input  logic [15:0] osc_frequency,
  input  logic [15:0] osc_duty,
  input  logic [2:0] osc_waveform,
  input  logic [7:0] osc_volume,
  input  logic [3:0] osc_crush,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] left_sample,
  output logic [7:0] right_sample
);
  import mosm_pkg::*;

  // state and control registers
  mosm_state_t       state;
  mosm_state_t       state_next;
  logic [3:0]        active;
  logic [31:0]       noise;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  osc;
  logic [15:0]       acc_left;
  logic [15:0]       acc_right;
  logic [NUM_OSC-1:0] set_valid;
  logic [NUM_OSC-1:0] phase_valid;

  // memories and read ports
  osc_settings_t     settings_mem [NUM_OSC];
  logic [15:0]       phase_mem [NUM_OSC];
  logic [OSC_W-1:0]  rd_addr;
  logic              rd_en;
  osc_settings_t     rd_settings;
  logic [15:0]       rd_phase;
  logic              rd_set_valid;
  logic              rd_phase_valid;

  // combinational helpers
  logic              in_accept;
  logic              settings_write;
  logic              sample_start;
  logic              last_osc;
  logic              out_load;
  logic              noise_bit;
  logic [CNT_W-1:0]  count_start;
  osc_settings_t     cur_settings;
  logic [15:0]       cur_phase;
  logic [15:0]       phase_next;
  logic [7:0]        crushed;
  logic signed [16:0] product;
  logic [OSC_W-1:0]  cur_addr;

  assign cfg_ready      = 1'b1;
  assign in_accept      = in_valid && in_ready;
  assign settings_write = in_accept && (kind == KIND_SETTINGS)
                          && (int'(osc_index) < NUM_OSC);
  assign sample_start   = in_accept && (kind == KIND_SAMPLE);
  assign last_osc       = (osc == count - CNT_W'(1));
  assign cur_addr       = osc[OSC_W-1:0];

  // mixed oscillator count, saturated to the number held
  always_comb begin
    if (int'(active) > NUM_OSC) begin
      count_start = CNT_W'(NUM_OSC);
    end else begin
      count_start = CNT_W'(active);
    end
  end

  assign noise_bit = noise[31] ^ noise[24] ^ noise[6] ^ noise[9];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_start) begin
          state_next = (count_start == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_osc) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid && (kind == KIND_SAMPLE);
      end
      ST_RUN: begin
        rd_en   = !last_osc;
        rd_addr = OSC_W'(osc + CNT_W'(1));
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= 4'd8;
      noise       <= 32'd1;
      set_valid   <= '0;
      phase_valid <= '0;
      out_valid   <= 1'b0;
      osc         <= '0;
      count       <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active <= active_oscillators;
      end
      if (sample_start) begin
        noise <= {noise[30:0], noise_bit};
        count <= count_start;
        osc   <= '0;
      end else if (state == ST_RUN) begin
        osc <= osc + CNT_W'(1);
      end
      if (settings_write) begin
        set_valid[OSC_W'(osc_index)] <= 1'b1;
      end
      if (state == ST_RUN) begin
        phase_valid[cur_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // settings memory
  always_ff @(posedge clk) begin
    if (settings_write) begin
      settings_mem[OSC_W'(osc_index)] <= '{
        frequency: osc_frequency,
        duty:      osc_duty,
        waveform:  osc_waveform,
        volume:    osc_volume,
        crush:     osc_crush
      };
    end
    if (rd_en) begin
      rd_settings  <= settings_mem[rd_addr];
      rd_set_valid <= set_valid[rd_addr];
    end
  end

  // phase memory, read ahead of the entry being written back
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      phase_mem[cur_addr] <= phase_next;
    end
    if (rd_en) begin
      rd_phase       <= phase_mem[rd_addr];
      rd_phase_valid <= phase_valid[rd_addr];
    end
  end

  // entries never written read as their reset values
  assign cur_settings = rd_set_valid ? rd_settings : SETTINGS_RESET;
  assign cur_phase    = rd_phase_valid ? rd_phase : 16'd0;

  // wave, bitcrush, phase step and scaled contribution
  assign phase_next = cur_phase + {2'b00, cur_settings.frequency[15:2]};
  assign crushed    = wave_value(cur_settings.waveform, cur_phase,
                                 cur_settings.duty, noise[5:0])
                      | crush_mask(cur_settings.crush);
  assign product    = $signed(crushed) * $signed({1'b0, cur_settings.volume});

  // left and right sums
  always_ff @(posedge clk) begin
    if (sample_start) begin
      acc_left  <= 16'd0;
      acc_right <= 16'd0;
    end else if (state == ST_RUN) begin
      if (osc[0]) begin
        acc_right <= acc_right + product[15:0];
      end else begin
        acc_left <= acc_left + product[15:0];
      end
    end
  end

  // output bytes: arithmetic shift then offset by 128
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (active == FOUR_CHANNELS) begin
        left_sample  <= {~acc_left[14], acc_left[13:7]};
        right_sample <= {~acc_right[14], acc_right[13:7]};
      end else begin
        left_sample  <= {~acc_left[15], acc_left[14:8]};
        right_sample <= {~acc_right[15], acc_right[14:8]};
      end
    end
  end

endmodule
